/* rtl/srmh_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// Shared types and codes for the shortest-remaining-time min-heap.
// Used by srmh_ctrl, srmh_datapath and the top level; depends on nothing.

package srmh_pkg;

  // One stored heap entry: ordering key above the process id.
  typedef struct packed {
    logic [15:0] tm;
    logic [7:0]  id;
  } entry_t;

  // Input command codes.
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Result status codes.
  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  // Read address select.
  typedef logic [2:0] rd_sel_t;
  localparam rd_sel_t RD_NONE   = 3'd0;
  localparam rd_sel_t RD_PARENT = 3'd1;
  localparam rd_sel_t RD_ROOT   = 3'd2;
  localparam rd_sel_t RD_LAST   = 3'd3;
  localparam rd_sel_t RD_LEFT   = 3'd4;
  localparam rd_sel_t RD_RIGHT  = 3'd5;

  // Write data select; every write goes to the current hole position.
  typedef logic [2:0] wr_sel_t;
  localparam wr_sel_t WR_NONE   = 3'd0;
  localparam wr_sel_t WR_PARENT = 3'd1;
  localparam wr_sel_t WR_NEW    = 3'd2;
  localparam wr_sel_t WR_CHOSEN = 3'd3;
  localparam wr_sel_t WR_MOVE   = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    accept_push;
    logic    accept_pop;
    logic    err_full;
    logic    err_empty;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    cap_root;
    logic    cap_move;
    logic    cap_left;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic parent_zero;
    logic push_less;
    logic has_left;
    logic has_right;
    logic move_less;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/srmh_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// Datapath of the min-heap: entry memory, hole position, entry count and result registers.
// Depends on srmh_pkg; driven by srmh_ctrl through srmh_pkg::cmd_t.

module srmh_datapath #(
  parameter int CAPACITY = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [7:0]          in_proc_id,
  input  wire logic [15:0]         in_remaining_time,
  input  wire srmh_pkg::cmd_t      cmd,
  output srmh_pkg::sts_t           sts,
  output logic [7:0]               out_id,
  output logic [15:0]              out_time,
  output logic [1:0]               out_status,
  output logic                     out_is_empty,
  output logic [6:0]               out_fill_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = AW + 2;

  srmh_pkg::entry_t mem [CAPACITY];

  logic [CW-1:0]          count_r;
  logic [AW-1:0]          pos_r;
  srmh_pkg::entry_t       new_r;
  srmh_pkg::entry_t       mv_r;
  srmh_pkg::entry_t       cand_r;
  logic [AW-1:0]          cand_addr_r;
  logic                   has_right_r;
  srmh_pkg::entry_t       rdata_r;
  logic [7:0]             res_id_r;
  logic [15:0]            res_time_r;
  srmh_pkg::status_t      status_r;

  logic [AW-1:0]          parent;
  logic [LW-1:0]          child_l;
  logic [LW-1:0]          child_r;
  logic [LW-1:0]          n_ext;
  logic                   pick_right;
  srmh_pkg::entry_t       chosen;
  logic [AW-1:0]          chosen_addr;
  logic [AW-1:0]          raddr;
  logic                   we;
  srmh_pkg::entry_t       wdata;

  assign parent     = (pos_r - AW'(1)) >> 1;
  assign child_l    = {1'b0, pos_r, 1'b1};
  assign child_r    = child_l + LW'(1);
  assign n_ext      = LW'(count_r);

  // The right child wins only when its key is strictly smaller.
  assign pick_right  = has_right_r && (rdata_r.tm < cand_r.tm);
  assign chosen      = pick_right ? rdata_r : cand_r;
  assign chosen_addr = pick_right ? (cand_addr_r + AW'(1)) : cand_addr_r;

  assign sts.full        = (count_r == CW'(CAPACITY));
  assign sts.empty       = (count_r == '0);
  assign sts.parent_zero = (parent == '0);
  assign sts.push_less   = (new_r.tm < rdata_r.tm);
  assign sts.has_left    = (child_l < n_ext);
  assign sts.has_right   = (child_r < n_ext);
  assign sts.move_less   = (mv_r.tm < chosen.tm);

  always_comb begin
    case (cmd.rd_sel)
      srmh_pkg::RD_PARENT: raddr = parent;
      srmh_pkg::RD_ROOT:   raddr = '0;
      srmh_pkg::RD_LAST:   raddr = AW'(count_r);
      srmh_pkg::RD_LEFT:   raddr = AW'(child_l);
      srmh_pkg::RD_RIGHT:  raddr = AW'(child_r);
      default:             raddr = '0;
    endcase
  end

  always_comb begin
    we    = 1'b1;
    wdata = new_r;
    case (cmd.wr_sel)
      srmh_pkg::WR_PARENT: wdata = rdata_r;
      srmh_pkg::WR_NEW:    wdata = new_r;
      srmh_pkg::WR_CHOSEN: wdata = chosen;
      srmh_pkg::WR_MOVE:   wdata = mv_r;
      default:             we    = 1'b0;
    endcase
  end

  // Simple dual-port style memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[pos_r] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.accept_push) begin
      count_r <= count_r + CW'(1);
    end else if (cmd.accept_pop) begin
      count_r <= count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_push) begin
      pos_r <= AW'(count_r);
      new_r <= {in_remaining_time, in_proc_id};
    end else if (cmd.cap_move) begin
      pos_r <= '0;
    end else if (cmd.wr_sel == srmh_pkg::WR_PARENT) begin
      pos_r <= parent;
    end else if (cmd.wr_sel == srmh_pkg::WR_CHOSEN) begin
      pos_r <= chosen_addr;
    end
    if (cmd.cap_move) begin
      mv_r <= rdata_r;
    end
    if (cmd.cap_left) begin
      cand_r      <= rdata_r;
      cand_addr_r <= AW'(child_l);
      has_right_r <= sts.has_right;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_push || cmd.accept_pop || cmd.err_full || cmd.err_empty) begin
      res_id_r   <= '0;
      res_time_r <= '0;
      if (cmd.err_full) begin
        status_r <= srmh_pkg::ST_FULL;
      end else if (cmd.err_empty) begin
        status_r <= srmh_pkg::ST_EMPTY;
      end else begin
        status_r <= srmh_pkg::ST_OK;
      end
    end else if (cmd.cap_root) begin
      res_id_r   <= rdata_r.id;
      res_time_r <= rdata_r.tm;
    end
  end

  assign out_id         = res_id_r;
  assign out_time       = res_time_r;
  assign out_status     = status_r;
  assign out_is_empty   = sts.empty;
  assign out_fill_count = 7'(count_r);

endmodule

`default_nettype wire

/* rtl/srmh_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// Controller state machine of the min-heap: sequences sift-up and sift-down.
// Depends on srmh_pkg; drives srmh_datapath through srmh_pkg::cmd_t.

module srmh_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic            in_command,
  input  wire srmh_pkg::sts_t  sts,
  output srmh_pkg::cmd_t       cmd,
  output logic                 busy,
  output logic                 out_valid
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_PUSH_RD  = 4'd1;
  localparam logic [3:0] S_PUSH_CMP = 4'd2;
  localparam logic [3:0] S_PUSH_WR  = 4'd3;
  localparam logic [3:0] S_POP_ROOT = 4'd4;
  localparam logic [3:0] S_POP_LAST = 4'd5;
  localparam logic [3:0] S_POP_MOVE = 4'd6;
  localparam logic [3:0] S_DN_L     = 4'd7;
  localparam logic [3:0] S_DN_R     = 4'd8;
  localparam logic [3:0] S_DN_CMP   = 4'd9;
  localparam logic [3:0] S_DN_WR    = 4'd10;
  localparam logic [3:0] S_DONE     = 4'd11;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_command == srmh_pkg::CMD_POP) begin
            if (sts.empty) begin
              cmd.err_empty = 1'b1;
              state_nxt     = S_DONE;
            end else begin
              cmd.accept_pop = 1'b1;
              state_nxt      = S_POP_ROOT;
            end
          end else begin
            if (sts.full) begin
              cmd.err_full = 1'b1;
              state_nxt    = S_DONE;
            end else begin
              cmd.accept_push = 1'b1;
              // An empty heap takes the new entry at the root directly.
              state_nxt = sts.empty ? S_PUSH_WR : S_PUSH_RD;
            end
          end
        end
      end
      S_PUSH_RD: begin
        cmd.rd_sel = srmh_pkg::RD_PARENT;
        state_nxt  = S_PUSH_CMP;
      end
      S_PUSH_CMP: begin
        if (sts.push_less) begin
          cmd.wr_sel = srmh_pkg::WR_PARENT;
          state_nxt  = sts.parent_zero ? S_PUSH_WR : S_PUSH_RD;
        end else begin
          cmd.wr_sel = srmh_pkg::WR_NEW;
          state_nxt  = S_DONE;
        end
      end
      S_PUSH_WR: begin
        cmd.wr_sel = srmh_pkg::WR_NEW;
        state_nxt  = S_DONE;
      end
      S_POP_ROOT: begin
        cmd.rd_sel = srmh_pkg::RD_ROOT;
        state_nxt  = S_POP_LAST;
      end
      S_POP_LAST: begin
        cmd.cap_root = 1'b1;
        cmd.rd_sel   = srmh_pkg::RD_LAST;
        state_nxt    = S_POP_MOVE;
      end
      S_POP_MOVE: begin
        cmd.cap_move = 1'b1;
        state_nxt    = S_DN_L;
      end
      S_DN_L: begin
        if (sts.has_left) begin
          cmd.rd_sel = srmh_pkg::RD_LEFT;
          state_nxt  = S_DN_R;
        end else begin
          state_nxt = S_DN_WR;
        end
      end
      S_DN_R: begin
        cmd.cap_left = 1'b1;
        cmd.rd_sel   = sts.has_right ? srmh_pkg::RD_RIGHT : srmh_pkg::RD_NONE;
        state_nxt    = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (sts.move_less) begin
          cmd.wr_sel = srmh_pkg::WR_MOVE;
          state_nxt  = S_DONE;
        end else begin
          cmd.wr_sel = srmh_pkg::WR_CHOSEN;
          state_nxt  = S_DN_L;
        end
      end
      S_DN_WR: begin
        cmd.wr_sel = srmh_pkg::WR_MOVE;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule

`default_nettype wire

/* rtl/shortest_remaining_min_heap_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Shortest-remaining-time min-heap: a binary min-heap of process ids keyed by remaining time.
// Top level; instantiates srmh_ctrl and srmh_datapath and uses srmh_pkg.
//
// Usage:
//   A command transfer happens at a rising edge where start is high and busy is
//   low. in_command selects push (in_proc_id, in_remaining_time are stored) or
//   pop (the entry with the least time is removed; the payload is ignored).
//   Each command produces exactly one result, shown for one cycle with
//   out_valid high; the receiver cannot stall it and must take it then.
//   out_id/out_time carry the popped entry (zero otherwise), out_status the
//   outcome (done, pop from empty, push to full), and out_is_empty and
//   out_fill_count the heap occupancy after the command.
// Sequencing:
//   The heap lives in a memory with one write and one registered read per
//   cycle, so each tree level walked costs memory accesses: a push walks up
//   from the last position toward the root and a pop walks down from the
//   root; a rejected command goes straight to its result. busy stays high
//   through the result cycle, so a new command is taken the cycle after.
// Reset:
//   A synchronous, active-low reset empties the heap; memory contents are not
//   cleared, as only entries below the fill count are ever read.

module shortest_remaining_min_heap_core #(
  parameter int CAPACITY = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  wire logic         in_command,
  input  wire logic [7:0]   in_proc_id,
  input  wire logic [15:0]  in_remaining_time,
  output logic              out_valid,
  output logic [7:0]        out_id,
  output logic [15:0]       out_time,
  output logic [1:0]        out_status,
  output logic              out_is_empty,
  output logic [6:0]        out_fill_count
);

  // Command and status bundles between the controller and the datapath.
  srmh_pkg::cmd_t cmd;
  srmh_pkg::sts_t sts;

  // The controller decides the sequence of memory reads and writes; it sees
  // only comparison, position and occupancy flags from the datapath.
  srmh_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy),
    .out_valid  (out_valid)
  );

  // The datapath holds the entry memory, the moving hole position and the
  // result registers, which stay stable through the result cycle.
  srmh_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_proc_id        (in_proc_id),
    .in_remaining_time (in_remaining_time),
    .cmd               (cmd),
    .sts               (sts),
    .out_id            (out_id),
    .out_time          (out_time),
    .out_status        (out_status),
    .out_is_empty      (out_is_empty),
    .out_fill_count    (out_fill_count)
  );

  // A result is strobed for a single cycle only.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // An accepted command always occupies the block in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
    else $error("command transfer did not make the block busy");

  // A pop rejected as empty must report an empty heap.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == srmh_pkg::ST_EMPTY) |-> out_is_empty)
    else $error("empty-pop status with a non-empty heap");

  // A push rejected as full cannot leave the heap empty.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == srmh_pkg::ST_FULL) |-> !out_is_empty)
    else $error("full-push status with an empty heap");

endmodule

`default_nettype wire
